>>> design/csgpm_pkg.sv
// ----------------------------------------------------------------------------
// csgpm_pkg
// Shared types, constants and tables for the stereo channel strip.
// ----------------------------------------------------------------------------
package csgpm_pkg;

    localparam int METER_CHANNELS = 2;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 20;
    localparam int DECAY_W  = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int DIV_W    = 32;
    localparam int DIVR_W   = 17;
    localparam int RECIP_W  = 32;
    localparam int ADDR_W   = 5;

    typedef enum logic [2:0] {
        REG_VOLUME  = 3'd0,
        REG_VCA     = 3'd1,
        REG_PAN     = 3'd2,
        REG_AUDIBLE = 3'd3,
        REG_SILENCE = 3'd4,
        REG_DECAY   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [11:0] volume_db;
        logic signed [10:0] vca_offset_db;
        logic signed [15:0] pan_position;
        logic               audible;
        logic signed [11:0] silence_threshold_db;
        logic [15:0]        meter_decay;
    } cfg_t;

    typedef struct packed {
        logic              busy;
        logic [GAIN_W-1:0] left;
        logic [GAIN_W-1:0] right;
    } gain_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod_l;
        logic signed [PROD_W-1:0] prod_r;
        logic                     audible;
        logic                     block_end;
    } item_t;

    localparam logic [63:0] DB_STEP_Q28  = 64'd270373970;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [31:0] P_ONE_Q28    = 32'h1000_0000;

    // Repeated squaring of the 1/16 dB step, rounded at each step.
    function automatic logic [8:0][31:0] db_step_tab();
        logic [8:0][31:0] tab;
        logic [63:0]      f;
        f = DB_STEP_Q28;
        for (int i = 0; i < 9; i++) begin
            tab[i] = f[31:0];
            f = (f * f + 64'h800_0000) >> 28;
        end
        return tab;
    endfunction

    localparam logic [8:0][31:0] DB_STEP = db_step_tab();

    // Divisor 10^(5-d) for decade d below five; the gain is
    // ((P + 8*K) >> 4) / K there, and (P*10^(d-5) + 8) >> 4 above.
    localparam logic [4:0][DIVR_W-1:0] DEC_DIV = {
        17'd10, 17'd100, 17'd1000, 17'd10000, 17'd100000
    };

    // Horner divisors: cosine entries 0..3, sine entries 4..7.
    localparam logic [7:0][6:0] POLY_DIV = {
        7'd6, 7'd20, 7'd42, 7'd72, 7'd2, 7'd12, 7'd30, 7'd56
    };

    // floor(2^32 / k), used as the reciprocal estimate.
    function automatic logic [RECIP_W-1:0] recip32(input logic [DIVR_W-1:0] k);
        logic [63:0] r;
        r = (64'd1 << 32) / 64'(k);
        return r[RECIP_W-1:0];
    endfunction

    function automatic logic [4:0][RECIP_W-1:0] dec_rcp_tab();
        logic [4:0][RECIP_W-1:0] tab;
        for (int i = 0; i < 5; i++) begin
            tab[i] = recip32(DEC_DIV[i]);
        end
        return tab;
    endfunction

    function automatic logic [7:0][RECIP_W-1:0] poly_rcp_tab();
        logic [7:0][RECIP_W-1:0] tab;
        for (int i = 0; i < 8; i++) begin
            tab[i] = recip32(DIVR_W'(POLY_DIV[i]));
        end
        return tab;
    endfunction

    localparam logic [4:0][RECIP_W-1:0] DEC_RCP  = dec_rcp_tab();
    localparam logic [7:0][RECIP_W-1:0] POLY_RCP = poly_rcp_tab();

endpackage

>>> design/csgpm_div.sv
// ----------------------------------------------------------------------------
// csgpm_div
// Divide by a table constant: reciprocal multiply, then one correction step.
// ----------------------------------------------------------------------------
module csgpm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [csgpm_pkg::DIV_W-1:0]   dividend,
    input  logic [csgpm_pkg::DIVR_W-1:0]  divisor,
    input  logic [csgpm_pkg::RECIP_W-1:0] recip,
    output logic                          done,
    output logic [csgpm_pkg::DIV_W-1:0]   quotient
);
    import csgpm_pkg::*;

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_EST  = 4'b0010,
        DV_MUL  = 4'b0100,
        DV_FIX  = 4'b1000
    } dst_t;

    dst_t                state_reg;
    logic                done_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [DIVR_W-1:0]   den_reg;
    logic [RECIP_W-1:0]  rcp_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [63:0]         prod_reg;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [DIV_W-1:0]    rem_w;

    // The estimate is the true quotient or one below it.
    always_comb begin
        case (state_reg)
            DV_EST: begin
                mul_a = num_reg;
                mul_b = rcp_reg;
            end
            DV_MUL: begin
                mul_a = prod_reg[63:32];
                mul_b = 32'(den_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        rem_w = num_reg - prod_reg[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= !start && (state_reg == DV_FIX);
            if (start) begin
                state_reg <= DV_EST;
            end else begin
                case (state_reg)
                    DV_EST: begin
                        state_reg <= DV_MUL;
                    end
                    DV_MUL: begin
                        state_reg <= DV_FIX;
                    end
                    default: begin
                        state_reg <= DV_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rcp_reg <= recip;
        end
        if (state_reg == DV_MUL) begin
            quo_reg <= prod_reg[63:32];
        end else if (state_reg == DV_FIX && rem_w >= DIV_W'(den_reg)) begin
            quo_reg <= quo_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/csgpm_gain.sv
// ----------------------------------------------------------------------------
// csgpm_gain
// Sequencer that derives left and right Q4.16 gains from fader, VCA and pan.
// ----------------------------------------------------------------------------
module csgpm_gain (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  csgpm_pkg::cfg_t   cfg,
    output csgpm_pkg::gain_t  gain
);
    import csgpm_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'b1 << 0,
        ST_G_CHK  = 18'b1 << 1,
        ST_G_MOD  = 18'b1 << 2,
        ST_G_POW  = 18'b1 << 3,
        ST_G_PUPD = 18'b1 << 4,
        ST_G_DEC  = 18'b1 << 5,
        ST_G_SCL  = 18'b1 << 6,
        ST_G_DIVW = 18'b1 << 7,
        ST_P_ANG  = 18'b1 << 8,
        ST_P_X    = 18'b1 << 9,
        ST_P_X2   = 18'b1 << 10,
        ST_P_MUL  = 18'b1 << 11,
        ST_P_DIV  = 18'b1 << 12,
        ST_P_DIVW = 18'b1 << 13,
        ST_P_SIN  = 18'b1 << 14,
        ST_P_SRES = 18'b1 << 15,
        ST_P_CG   = 18'b1 << 16,
        ST_P_CGR  = 18'b1 << 17
    } gst_t;

    gst_t              state_reg, state_next;
    logic              ch_reg, ch_next;
    logic [3:0]        idx_reg, idx_next;
    logic [11:0]       rem_reg, rem_next;
    logic [2:0]        dec_reg, dec_next;
    logic [31:0]       p_reg, p_next;
    logic [31:0]       g_reg, g_next;
    logic [29:0]       x_reg, x_next;
    logic [29:0]       x2_reg, x2_next;
    logic [30:0]       a_reg, a_next;
    logic              sin_reg, sin_next;
    logic [1:0]        k_reg, k_next;
    logic [GAIN_W-1:0] gl_reg, gl_next;
    logic [GAIN_W-1:0] gr_reg, gr_next;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod_reg;

    logic               div_start;
    logic [DIV_W-1:0]   div_num;
    logic [DIVR_W-1:0]  div_den;
    logic [RECIP_W-1:0] div_rcp;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    logic signed [12:0] sum_w;
    logic signed [12:0] sat_w;
    logic [11:0]        u_w;
    logic               silent_w;
    logic signed [15:0] pan_w;
    logic [15:0]        t_w;
    logic [15:0]        tt_w;
    logic               sin_w;
    logic [14:0]        arg_w;
    logic [63:0]        xr_w;
    logic [29:0]        x_w;
    logic [63:0]        pr_w;
    logic [63:0]        sc_w;
    logic [32:0]        rnd_w;
    logic [63:0]        cg_w;
    logic [25:0]        v_w;
    logic [GAIN_W-1:0]  vs_w;

    always_comb begin
        sum_w    = 13'(cfg.volume_db) + 13'(cfg.vca_offset_db);
        silent_w = (cfg.volume_db <= cfg.silence_threshold_db) || (sum_w <= -13'sd1600);
        sat_w    = (sum_w > 13'sd576) ? 13'sd576 : sum_w;
        u_w      = 12'(sat_w + 13'sd1600);

        if (cfg.pan_position < -16'sd16384) begin
            pan_w = -16'sd16384;
        end else if (cfg.pan_position > 16'sd16384) begin
            pan_w = 16'sd16384;
        end else begin
            pan_w = cfg.pan_position;
        end
        t_w   = 16'(pan_w + 16'sd16384);
        tt_w  = ch_reg ? 16'(16'd32768 - t_w) : t_w;
        sin_w = tt_w > 16'd16384;
        arg_w = sin_w ? 15'(16'd32768 - tt_w) : tt_w[14:0];

        xr_w  = prod_reg + 64'd32768;
        x_w   = xr_w[45:16];
        pr_w  = prod_reg + 64'h800_0000;
        sc_w  = prod_reg + 64'd8;
        cg_w  = prod_reg + 64'h20_0000_0000;
        v_w   = cg_w[63:38];
        vs_w  = (v_w > 26'hF_FFFF) ? 20'hF_FFFF : v_w[GAIN_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        dec_next   = dec_reg;
        p_next     = p_reg;
        g_next     = g_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        a_next     = a_reg;
        sin_next   = sin_reg;
        k_next     = k_reg;
        gl_next    = gl_reg;
        gr_next    = gr_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        div_rcp    = '0;
        rnd_w      = '0;

        case (state_reg)
            ST_IDLE: begin
            end
            ST_G_CHK: begin
                ch_next = 1'b0;
                if (silent_w) begin
                    g_next     = '0;
                    state_next = ST_P_ANG;
                end else begin
                    rem_next   = u_w;
                    dec_next   = '0;
                    state_next = ST_G_MOD;
                end
            end
            ST_G_MOD: begin
                if (rem_reg >= 12'd320) begin
                    rem_next = rem_reg - 12'd320;
                    dec_next = dec_reg + 1'b1;
                end else begin
                    idx_next   = '0;
                    p_next     = P_ONE_Q28;
                    state_next = ST_G_POW;
                end
            end
            ST_G_POW: begin
                mul_a = p_reg;
                mul_b = DB_STEP[idx_reg];
                if (rem_reg[idx_reg]) begin
                    state_next = ST_G_PUPD;
                end else if (idx_reg == 4'd8) begin
                    state_next = ST_G_DEC;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_G_PUPD: begin
                p_next = pr_w[59:28];
                if (idx_reg == 4'd8) begin
                    state_next = ST_G_DEC;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_G_POW;
                end
            end
            ST_G_DEC: begin
                // Upper decades scale by 10^(d-5) and divide by 16; lower ones divide by 16 * 10^(5-d).
                if (dec_reg >= 3'd5) begin
                    mul_a      = p_reg;
                    mul_b      = (dec_reg == 3'd6) ? 32'd10 : 32'd1;
                    state_next = ST_G_SCL;
                end else begin
                    rnd_w      = 33'(p_reg) + 33'({DEC_DIV[dec_reg], 3'b000});
                    div_start  = 1'b1;
                    div_num    = DIV_W'(rnd_w[32:4]);
                    div_den    = DEC_DIV[dec_reg];
                    div_rcp    = DEC_RCP[dec_reg];
                    state_next = ST_G_DIVW;
                end
            end
            ST_G_SCL: begin
                g_next     = sc_w[35:4];
                state_next = ST_P_ANG;
            end
            ST_G_DIVW: begin
                if (div_done) begin
                    g_next     = div_q[31:0];
                    state_next = ST_P_ANG;
                end
            end
            ST_P_ANG: begin
                sin_next   = sin_w;
                mul_a      = 32'(arg_w);
                mul_b      = PI_Q30;
                state_next = ST_P_X;
            end
            ST_P_X: begin
                x_next     = x_w;
                mul_a      = 32'(x_w);
                mul_b      = 32'(x_w);
                state_next = ST_P_X2;
            end
            ST_P_X2: begin
                x2_next    = prod_reg[59:30];
                a_next     = Q30_ONE;
                k_next     = '0;
                state_next = ST_P_MUL;
            end
            ST_P_MUL: begin
                mul_a      = 32'(x2_reg);
                mul_b      = 32'(a_reg);
                state_next = ST_P_DIV;
            end
            ST_P_DIV: begin
                div_start  = 1'b1;
                div_num    = prod_reg[61:30];
                div_den    = DIVR_W'(POLY_DIV[{sin_reg, k_reg}]);
                div_rcp    = POLY_RCP[{sin_reg, k_reg}];
                state_next = ST_P_DIVW;
            end
            ST_P_DIVW: begin
                if (div_done) begin
                    a_next = Q30_ONE - div_q[30:0];
                    if (k_reg == 2'd3) begin
                        state_next = sin_reg ? ST_P_SIN : ST_P_CG;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_P_MUL;
                    end
                end
            end
            ST_P_SIN: begin
                mul_a      = 32'(x_reg);
                mul_b      = 32'(a_reg);
                state_next = ST_P_SRES;
            end
            ST_P_SRES: begin
                a_next     = prod_reg[60:30];
                state_next = ST_P_CG;
            end
            ST_P_CG: begin
                mul_a      = g_reg;
                mul_b      = 32'(a_reg);
                state_next = ST_P_CGR;
            end
            ST_P_CGR: begin
                if (!ch_reg) begin
                    gl_next    = vs_w;
                    ch_next    = 1'b1;
                    state_next = ST_P_ANG;
                end else begin
                    gr_next    = vs_w;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_G_CHK;
            end
        endcase

        // Start over on any register write that moves the gains.
        if (restart) begin
            state_next = ST_G_CHK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_G_CHK;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        dec_reg  <= dec_next;
        p_reg    <= p_next;
        g_reg    <= g_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        a_reg    <= a_next;
        sin_reg  <= sin_next;
        k_reg    <= k_next;
        gl_reg   <= gl_next;
        gr_reg   <= gr_next;
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    csgpm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .recip    (div_rcp),
        .done     (div_done),
        .quotient (div_q)
    );

    assign gain.busy  = state_reg != ST_IDLE;
    assign gain.left  = gl_reg;
    assign gain.right = gr_reg;

endmodule

>>> design/csgpm_front.sv
// ----------------------------------------------------------------------------
// csgpm_front
// Input stage: take a sample pair, tag it and form the gain products.
// ----------------------------------------------------------------------------
module csgpm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [csgpm_pkg::SAMPLE_W-1:0] s_sample_left,
    input  logic signed [csgpm_pkg::SAMPLE_W-1:0] s_sample_right,
    input  logic                               s_block_end,
    input  csgpm_pkg::gain_t                   gain,
    input  logic                               audible,
    output logic                               push_valid,
    input  logic                               push_ready,
    output csgpm_pkg::item_t                   push_item
);
    import csgpm_pkg::*;

    localparam bit TWO_CH = METER_CHANNELS >= 2;

    logic              fv_reg;
    item_t             item_reg;
    logic              front_ready;
    logic              accept;
    logic [GAIN_W-1:0] gr_w;

    assign front_ready = !fv_reg || push_ready;
    assign s_ready     = front_ready && !gain.busy;
    assign accept      = s_valid && s_ready;
    assign gr_w        = TWO_CH ? gain.right : gain.left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (accept) begin
            fv_reg <= 1'b1;
        end else if (push_ready) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.prod_l    <= s_sample_left * $signed({1'b0, gain.left});
            item_reg.prod_r    <= s_sample_right * $signed({1'b0, gr_w});
            item_reg.audible   <= audible;
            item_reg.block_end <= s_block_end;
        end
    end

    assign push_valid = fv_reg;
    assign push_item  = item_reg;

endmodule

>>> design/csgpm_queue.sv
// ----------------------------------------------------------------------------
// csgpm_queue
// Two-entry queue between the input stage and the output stage.
// ----------------------------------------------------------------------------
module csgpm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  csgpm_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output csgpm_pkg::item_t pop_item
);
    import csgpm_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/csgpm_back.sv
// ----------------------------------------------------------------------------
// csgpm_back
// Output stage: round and saturate, track block peaks, update meters.
// ----------------------------------------------------------------------------
module csgpm_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  csgpm_pkg::item_t                    pop_item,
    input  logic [csgpm_pkg::DECAY_W-1:0]       meter_decay,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [csgpm_pkg::SAMPLE_W-1:0] m_out_left,
    output logic signed [csgpm_pkg::SAMPLE_W-1:0] m_out_right,
    output logic [csgpm_pkg::SAMPLE_W-1:0]      m_meter_left,
    output logic [csgpm_pkg::SAMPLE_W-1:0]      m_meter_right
);
    import csgpm_pkg::*;

    localparam bit TWO_CH = METER_CHANNELS >= 2;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0] q;
        logic signed [PROD_W-16:0] y;
        q = {prod[PROD_W-1], prod} + (PROD_W+1)'(32768);
        y = q[PROD_W:16];
        if (y > (PROD_W-15)'(8388607)) begin
            return 24'sh7F_FFFF;
        end else if (y < -(PROD_W-15)'(8388608)) begin
            return 24'sh80_0000;
        end
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] y);
        return y[SAMPLE_W-1] ? SAMPLE_W'(-y) : y;
    endfunction

    logic                       ov_reg;
    logic signed [SAMPLE_W-1:0] yl_reg, yr_reg;
    logic [SAMPLE_W-1:0]        ml_reg, mr_reg;
    logic [SAMPLE_W-1:0]        peak_l_reg, peak_l_next;
    logic [SAMPLE_W-1:0]        peak_r_reg, peak_r_next;
    logic [SAMPLE_W-1:0]        lvl_l_reg, lvl_l_next;
    logic [SAMPLE_W-1:0]        lvl_r_reg, lvl_r_next;
    logic signed [SAMPLE_W-1:0] yl_w, yr_w;
    logic [SAMPLE_W-1:0]        pl_w, pr_w;
    logic [SAMPLE_W+DECAY_W-1:0] dl_w, dr_w;
    logic                       pop;

    assign pop_ready = !ov_reg || m_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        yl_w = '0;
        yr_w = '0;
        pl_w = peak_l_reg;
        pr_w = peak_r_reg;
        if (pop_item.audible) begin
            yl_w = round_sat(pop_item.prod_l);
            yr_w = round_sat(pop_item.prod_r);
            if (mag(yl_w) > pl_w) begin
                pl_w = mag(yl_w);
            end
            if (TWO_CH && mag(yr_w) > pr_w) begin
                pr_w = mag(yr_w);
            end
        end
        dl_w = lvl_l_reg * meter_decay;
        dr_w = lvl_r_reg * meter_decay;

        peak_l_next = pl_w;
        peak_r_next = pr_w;
        lvl_l_next  = lvl_l_reg;
        lvl_r_next  = lvl_r_reg;
        if (pop_item.block_end) begin
            lvl_l_next  = (pl_w > dl_w[SAMPLE_W+DECAY_W-1:DECAY_W]) ?
                          pl_w : dl_w[SAMPLE_W+DECAY_W-1:DECAY_W];
            lvl_r_next  = !TWO_CH ? '0 :
                          (pr_w > dr_w[SAMPLE_W+DECAY_W-1:DECAY_W]) ?
                          pr_w : dr_w[SAMPLE_W+DECAY_W-1:DECAY_W];
            peak_l_next = '0;
            peak_r_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg     <= 1'b0;
            peak_l_reg <= '0;
            peak_r_reg <= '0;
            lvl_l_reg  <= '0;
            lvl_r_reg  <= '0;
        end else begin
            if (pop) begin
                ov_reg     <= 1'b1;
                peak_l_reg <= peak_l_next;
                peak_r_reg <= peak_r_next;
                lvl_l_reg  <= lvl_l_next;
                lvl_r_reg  <= lvl_r_next;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            yl_reg <= yl_w;
            yr_reg <= yr_w;
            ml_reg <= lvl_l_next;
            mr_reg <= lvl_r_next;
        end
    end

    assign m_valid       = ov_reg;
    assign m_out_left    = yl_reg;
    assign m_out_right   = yr_reg;
    assign m_meter_left  = ml_reg;
    assign m_meter_right = mr_reg;

endmodule

>>> design/stereo_channel_gain_pan_meter.sv
// Path: an accepted request passes the front, queue and output registers to m_*.
// Throughput: one sample pair per cycle while results are taken every cycle.
// Gains come from a shared multiplier and a reciprocal-multiply divider; s_ready
// is low while a recompute runs.
// Reset: synchronous, active low; registers load defaults, meters clear and
// the gain recompute starts at once, so s_ready stays low until it finishes.
// ----------------------------------------------------------------------------
// stereo_channel_gain_pan_meter
// Stereo channel strip: fader and VCA gain, equal-power pan, saturation and
// per-block peak meters, with an APB-style register port.
// ----------------------------------------------------------------------------
module stereo_channel_gain_pan_meter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csgpm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [csgpm_pkg::SAMPLE_W-1:0] s_sample_left,
    input  logic signed [csgpm_pkg::SAMPLE_W-1:0] s_sample_right,
    input  logic                                s_block_end,
    // result requests
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [csgpm_pkg::SAMPLE_W-1:0] m_out_left,
    output logic signed [csgpm_pkg::SAMPLE_W-1:0] m_out_right,
    output logic [csgpm_pkg::SAMPLE_W-1:0]      m_meter_left,
    output logic [csgpm_pkg::SAMPLE_W-1:0]      m_meter_right
);
    import csgpm_pkg::*;

    cfg_t       cfg_reg;
    gain_t      gain;
    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       restart;

    logic       push_valid, push_ready;
    item_t      push_item;
    logic       pop_valid, pop_ready;
    item_t      pop_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Only writes that move the gains restart the gain sequencer.
    assign restart = cfg_wr && (cfg_idx == REG_VOLUME || cfg_idx == REG_VCA ||
                                cfg_idx == REG_PAN    || cfg_idx == REG_SILENCE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volume_db            <= 12'sd0;
            cfg_reg.vca_offset_db        <= 11'sd0;
            cfg_reg.pan_position         <= 16'sd0;
            cfg_reg.audible              <= 1'b1;
            cfg_reg.silence_threshold_db <= -12'sd1600;
            cfg_reg.meter_decay          <= 16'd60000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VOLUME:  cfg_reg.volume_db            <= pwdata[11:0];
                REG_VCA:     cfg_reg.vca_offset_db        <= pwdata[10:0];
                REG_PAN:     cfg_reg.pan_position         <= pwdata[15:0];
                REG_AUDIBLE: cfg_reg.audible              <= pwdata[0];
                REG_SILENCE: cfg_reg.silence_threshold_db <= pwdata[11:0];
                REG_DECAY:   cfg_reg.meter_decay          <= pwdata[15:0];
                default: begin
                    // drop writes outside the register map
                end
            endcase
        end
    end

    // Read back, sign-extending the signed registers.
    always_comb begin
        case (cfg_idx)
            REG_VOLUME:  prdata = 32'(cfg_reg.volume_db);
            REG_VCA:     prdata = 32'(cfg_reg.vca_offset_db);
            REG_PAN:     prdata = 32'(cfg_reg.pan_position);
            REG_AUDIBLE: prdata = {31'd0, cfg_reg.audible};
            REG_SILENCE: prdata = 32'(cfg_reg.silence_threshold_db);
            REG_DECAY:   prdata = {16'd0, cfg_reg.meter_decay};
            default:     prdata = '0;
        endcase
    end

    // Gain sequencer: runs after reset and after each gain-related write.
    csgpm_gain u_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .cfg     (cfg_reg),
        .gain    (gain)
    );

    // Front: accept requests, tag mute state, multiply by the channel gains.
    csgpm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_left  (s_sample_left),
        .s_sample_right (s_sample_right),
        .s_block_end    (s_block_end),
        .gain           (gain),
        .audible        (cfg_reg.audible),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Queue: decouple the front from result backpressure.
    csgpm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: round, saturate, meter and hold the result in the output register.
    csgpm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .meter_decay   (cfg_reg.meter_decay),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_left    (m_out_left),
        .m_out_right   (m_out_right),
        .m_meter_left  (m_meter_left),
        .m_meter_right (m_meter_right)
    );

    // A volume write must block new requests until the gains are rebuilt.
    a_volume_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && cfg_idx == REG_VOLUME) |=> !s_ready)
        else $error("request taken right after a volume write");

    // Coming out of reset the gains are not yet valid.
    a_reset_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready)
        else $error("request taken before reset gains were computed");

    // A muted sample pair must leave as silence.
    a_mute_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready && !pop_item.audible) |=>
            (m_out_left == '0 && m_out_right == '0))
        else $error("muted sample produced nonzero output");

endmodule

>>> sim/tb_stereo_channel_gain_pan_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_channel_gain_pan_meter
// Self-checking bench for the stereo channel strip: a queue-fed driver and a
// monitor check every scaled sample pair and meter level against a bit-exact
// predictor of gain, pan, saturation and peak metering, over many settings.
// ----------------------------------------------------------------------------
module tb_stereo_channel_gain_pan_meter;
    import csgpm_pkg::*;

    typedef struct {
        logic signed [23:0] sl;
        logic signed [23:0] sr;
        logic               be;
    } sample_req_t;

    typedef struct {
        logic signed [23:0] ol;
        logic signed [23:0] orr;
        logic [23:0]        ml;
        logic [23:0]        mr;
    } strip_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_sample_left = '0, s_sample_right = '0;
    logic s_block_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_out_left, m_out_right;
    logic [23:0] m_meter_left, m_meter_right;

    stereo_channel_gain_pan_meter uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the registers and the strip state.
    logic signed [11:0] sh_volume, sh_silence;
    logic signed [10:0] sh_vca;
    logic signed [15:0] sh_pan;
    logic               sh_audible;
    logic [15:0]        sh_decay;
    logic [19:0]        gain_l, gain_r;
    logic [23:0]        peak_l, peak_r, level_l, level_r;

    sample_req_t pending_samples[$];
    strip_out_t  expected_outs[$];
    int          errors = 0;
    int          accepted_cnt = 0;
    bit          quiet = 1'b0;

    function automatic longint unsigned cos_q30(longint unsigned x);
        longint unsigned x2, a;
        x2 = (x * x) >> 30;
        a = 64'd1073741824 - x2 / 56;
        a = 64'd1073741824 - ((x2 * a) >> 30) / 30;
        a = 64'd1073741824 - ((x2 * a) >> 30) / 12;
        return 64'd1073741824 - ((x2 * a) >> 30) / 2;
    endfunction

    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2, a;
        x2 = (x * x) >> 30;
        a = 64'd1073741824 - x2 / 72;
        a = 64'd1073741824 - ((x2 * a) >> 30) / 42;
        a = 64'd1073741824 - ((x2 * a) >> 30) / 20;
        a = 64'd1073741824 - ((x2 * a) >> 30) / 6;
        return (x * a) >> 30;
    endfunction

    function automatic longint unsigned pan_curve(longint unsigned t);
        if (t <= 16384)
            return cos_q30((t * 64'd3373259426 + 32768) >> 16);
        return sin_q30(((32768 - t) * 64'd3373259426 + 32768) >> 16);
    endfunction

    function automatic longint unsigned fader_gain_q24();
        longint s;
        longint unsigned u, r, p, f, dec;
        if (sh_volume <= sh_silence) return 0;
        s = longint'(sh_volume) + longint'(sh_vca);
        if (s <= -1600) return 0;
        if (s > 576) s = 576;
        u = s + 1600;
        r = u % 320;
        p = 64'd1 << 28;
        f = 64'd270373970;
        for (int i = 0; i < 9; i++) begin
            if (r[i]) p = (p * f + (64'd1 << 27)) >> 28;
            f = (f * f + (64'd1 << 27)) >> 28;
        end
        dec = 1;
        for (int i = 0; i < int'(u / 320); i++) dec = dec * 10;
        return (p * dec + 800000) / 1600000;
    endfunction

    function automatic logic [19:0] sat_gain(longint unsigned g, longint unsigned c);
        longint unsigned v;
        v = (g * c + (64'd1 << 37)) >> 38;
        return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    task automatic refresh_gains();
        longint p;
        longint unsigned t, g;
        p = sh_pan;
        if (p < -16384) p = -16384;
        if (p > 16384) p = 16384;
        t = p + 16384;
        g = fader_gain_q24();
        gain_l = sat_gain(g, pan_curve(t));
        gain_r = sat_gain(g, pan_curve(32768 - t));
    endtask

    function automatic logic signed [23:0] scale_sample(logic signed [23:0] x, logic [19:0] g);
        longint q;
        q = (longint'(x) * longint'({1'b0, g}) + 32768) >>> 16;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[23:0];
    endfunction

    // Advance the strip by one request and queue the result it produces.
    task automatic predict_strip(sample_req_t rq);
        strip_out_t e;
        logic [23:0] al, ar;
        logic [39:0] dl, dr;
        e.ol = '0;
        e.orr = '0;
        if (sh_audible) begin
            e.ol = scale_sample(rq.sl, gain_l);
            e.orr = scale_sample(rq.sr, gain_r);
            al = e.ol[23] ? -e.ol : e.ol;
            ar = e.orr[23] ? -e.orr : e.orr;
            if (al > peak_l) peak_l = al;
            if (ar > peak_r) peak_r = ar;
        end
        if (rq.be) begin
            dl = (40'(level_l) * sh_decay) >> 16;
            dr = (40'(level_r) * sh_decay) >> 16;
            level_l = (peak_l > dl) ? peak_l : dl[23:0];
            level_r = (peak_r > dr) ? peak_r : dr[23:0];
            peak_l = '0;
            peak_r = '0;
        end
        e.ml = level_l;
        e.mr = level_r;
        expected_outs.push_back(e);
    endtask

    // Driver: hold each request until accepted, insert random gaps.
    int src_gap = 0;
    always @(posedge aclk) begin : drive_samples
        logic take;
        take = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (take) begin
                predict_strip(pending_samples[0]);
                void'(pending_samples.pop_front());
                accepted_cnt++;
            end
            if (s_valid && !take) begin
                // keep the request stable
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 5);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_sample_left <= pending_samples[0].sl;
                    s_sample_right <= pending_samples[0].sr;
                    s_block_end <= pending_samples[0].be;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the pipeline fills and stalls input.
    logic long_hold = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;
    always @(posedge aclk) begin
        if (!hold_done && accepted_cnt >= 120) begin
            hold_cnt++;
            long_hold <= (hold_cnt < 400);
            if (hold_cnt >= 400) hold_done = 1'b1;
        end
    end

    // Monitor: compare each result with the oldest expectation.
    int sink_gap = 0;
    always @(posedge aclk) begin : check_outputs
        strip_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outs.size() == 0) begin
                $error("unexpected result out_left=%0d", m_out_left);
                errors++;
            end else begin
                e = expected_outs.pop_front();
                if (m_out_left !== e.ol) begin
                    $error("out_left expected %0d actual %0d", e.ol, m_out_left);
                    errors++;
                end
                if (m_out_right !== e.orr) begin
                    $error("out_right expected %0d actual %0d", e.orr, m_out_right);
                    errors++;
                end
                if (m_meter_left !== e.ml) begin
                    $error("meter_left expected %0d actual %0d", e.ml, m_meter_left);
                    errors++;
                end
                if (m_meter_right !== e.mr) begin
                    $error("meter_right expected %0d actual %0d", e.mr, m_meter_right);
                    errors++;
                end
            end
        end
        if (!aresetn || long_hold) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_sample(logic signed [23:0] l, logic signed [23:0] r, logic be);
        sample_req_t rq;
        rq.sl = l;
        rq.sr = r;
        rq.be = be;
        pending_samples.push_back(rq);
    endtask

    // Drain: every request accepted, every result seen, then a few spare cycles.
    task automatic drain();
        while (pending_samples.size() > 0 || expected_outs.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(int idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_VOLUME:  sh_volume = value[11:0];
            REG_VCA:     sh_vca = value[10:0];
            REG_PAN:     sh_pan = value[15:0];
            REG_AUDIBLE: sh_audible = value[0];
            REG_SILENCE: sh_silence = value[11:0];
            REG_DECAY:   sh_decay = value[15:0];
            default: ;
        endcase
        refresh_gains();
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return $urandom_range(0, 15) - 8;
            3: return $signed(24'($urandom)) >>> $urandom_range(0, 20);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_field(int w, int lo, int hi);
        if ($urandom_range(0, 3) == 0) return 32'($urandom) & ((32'd1 << w) - 1);
        return 32'($urandom_range(0, hi - lo) + lo);
    endfunction

    initial begin
        sh_volume = 0;
        sh_vca = 0;
        sh_pan = 0;
        sh_audible = 1'b1;
        sh_silence = -1600;
        sh_decay = 16'd60000;
        peak_l = '0;
        peak_r = '0;
        level_l = '0;
        level_r = '0;
        refresh_gains();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: sample extremes, sign patterns and block ends.
        push_sample(24'sh7FFFFF, 24'sh800000, 1'b0);
        push_sample(24'sh800000, 24'sh7FFFFF, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(1, -1, 1'b1);
        push_sample(24'sh555555, 24'shAAAAAA, 1'b0);
        push_sample(24'shAAAAAA, 24'sh555555, 1'b1);
        push_sample(0, 0, 1'b1);
        drain();

        // Large gain sum clamps and channel gain saturates, pan hard right.
        reg_write(REG_VOLUME, 32'd2047);
        reg_write(REG_VCA, 32'd1023);
        reg_write(REG_PAN, 32'd16384);
        push_sample(24'sh7FFFFF, 24'sh800000, 1'b0);
        push_sample(24'sh000123, -24'sh000123, 1'b1);
        drain();

        // Pan beyond full left clamps; decay extremes.
        reg_write(REG_VCA, 32'h7C0);
        reg_write(REG_PAN, 32'h8000);
        reg_write(REG_DECAY, 32'd65535);
        push_sample(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        push_sample(0, 0, 1'b1);
        drain();
        reg_write(REG_DECAY, 32'd0);
        reg_write(REG_PAN, 32'h7FFF);
        push_sample(24'sh800000, 24'sh800000, 1'b0);
        push_sample(0, 0, 1'b1);
        drain();

        // Block partly muted: peaks from the audible part still count.
        reg_write(REG_DECAY, 32'd60000);
        reg_write(REG_PAN, 32'd0);
        push_sample(24'sh400000, 24'sh200000, 1'b0);
        drain();
        reg_write(REG_AUDIBLE, 32'd0);
        push_sample(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        push_sample(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        drain();

        // Silence threshold, sum at the floor and ignored register indexes.
        reg_write(REG_AUDIBLE, 32'd1);
        reg_write(REG_SILENCE, 32'd0);
        reg_write(REG_VOLUME, 32'd0);
        reg_write(6, 32'hFFFFFFFF);
        reg_write(7, 32'h0);
        push_sample(24'sh7FFFFF, 24'sh800000, 1'b1);
        drain();
        reg_write(REG_SILENCE, 32'hFFFFF9C0);
        reg_write(REG_VOLUME, 32'hFFFFFC7C);
        reg_write(REG_VCA, 32'hFFFFFD00);
        push_sample(24'sh7FFFFF, 24'sh800000, 1'b1);
        drain();

        // Random phases with fresh settings each time; the last runs without gaps.
        for (int ph = 0; ph < 9; ph++) begin
            reg_write(REG_VOLUME, rand_field(12, -1600, 192));
            reg_write(REG_VCA, rand_field(11, -768, 384));
            reg_write(REG_PAN, rand_field(16, -16384, 16384));
            reg_write(REG_AUDIBLE, ($urandom_range(0, 4) != 0));
            reg_write(REG_SILENCE, rand_field(12, -1600, 0));
            reg_write(REG_DECAY, 32'($urandom_range(0, 65535)));
            if (ph == 8) quiet = 1'b1;
            for (int k = 0; k < 50; k++)
                push_sample(rand_sample(), rand_sample(), ($urandom_range(0, 7) == 0));
            drain();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_outs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
